FILE: rtl/lob_pkg.sv
// Shared types, codes and defaults of the limit order book.
package lob_pkg;

  localparam int ORDER_SLOTS_DEF  = 1024;
  localparam int PRICE_LEVELS_DEF = 1024;
  localparam int LIVE_W           = 11;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_EXEC   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DUP_ID   = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_ZERO     = 3'd3,
    ST_OVERFILL = 3'd4,
    ST_RANGE    = 3'd5,
    ST_FULL     = 3'd6,
    ST_SPARE    = 3'd7
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cnt_clr;
    logic clr_wr;
    logic load_in;
    logic rd_find;
    logic apply;
    logic rd_best;
    logic load_out;
  } lob_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;
  } lob_sts_t;

endpackage

FILE: rtl/lob_ctrl.sv
// Controller state machine of the limit order book.
module lob_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lob_pkg::lob_cmd_t cmd,
  input  lob_pkg::lob_sts_t sts
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_FIND   = 8'b0000_0100,
    S_DRAIN1 = 8'b0000_1000,
    S_APPLY  = 8'b0001_0000,
    S_BEST   = 8'b0010_0000,
    S_DRAIN2 = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_next  = S_FIND;
        end
      end
      S_FIND: begin
        cmd.rd_find = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_DRAIN1;
        end
      end
      S_DRAIN1: state_next = S_APPLY;
      S_APPLY: begin
        cmd.apply   = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_next  = S_BEST;
      end
      S_BEST: begin
        cmd.rd_best = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_DRAIN2;
        end
      end
      S_DRAIN2: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/lob_dp.sv
// Datapath of the limit order book: order store, scans and result register.
module lob_dp #(
  parameter int ORDER_SLOTS  = lob_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_LEVELS = lob_pkg::PRICE_LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lob_pkg::lob_cmd_t            cmd,
  output lob_pkg::lob_sts_t            sts,
  input  logic                         cfg_write,
  input  logic [31:0]                  cfg_data,
  input  logic [1:0]                   func,
  input  logic [63:0]                  evt_id,
  input  logic                         side,
  input  logic [31:0]                  price,
  input  logic [31:0]                  quantity,
  output logic [2:0]                   status,
  output logic                         bid_valid,
  output logic [31:0]                  bid_price,
  output logic [63:0]                  bid_front_id,
  output logic                         ask_valid,
  output logic [31:0]                  ask_price,
  output logic [63:0]                  ask_front_id,
  output logic [lob_pkg::LIVE_W-1:0]   live_orders
);

  localparam int AW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CW = $clog2(ORDER_SLOTS + 1);
  localparam int LW = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;

  typedef struct packed {
    logic          used;
    logic [63:0]   id;
    logic          side;
    logic [LW-1:0] level;
    logic [31:0]   qty;
    logic [63:0]   seq;
  } slot_t;

  slot_t mem [ORDER_SLOTS];

  logic [31:0]   lowest_price;
  logic [AW-1:0] cnt;
  logic [CW-1:0] order_count;
  logic [63:0]   seq_ctr;

  // Latched event.
  lob_pkg::func_t func_q;
  logic [63:0]    id_q;
  logic           side_q;
  logic [31:0]    price_q;
  logic [31:0]    qty_q;

  // Read pipeline.
  slot_t         rd_word;
  logic [AW-1:0] rd_idx;
  logic          rd_find_v;
  logic          rd_best_v;

  // Lookup results.
  logic          hit;
  logic [AW-1:0] hit_idx;
  slot_t         hit_word;
  logic          free_found;
  logic [AW-1:0] free_idx;

  // Best price search.
  logic          bid_v;
  logic [LW-1:0] bid_lvl;
  logic [63:0]   bid_seq;
  logic [63:0]   bid_id;
  logic          ask_v;
  logic [LW-1:0] ask_lvl;
  logic [63:0]   ask_seq;
  logic [63:0]   ask_id;

  lob_pkg::status_t stat_now;
  lob_pkg::status_t stat_q;
  logic [31:0]      diff;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  slot_t            wr_data;
  logic             rd_en;
  logic             live;
  logic             bid_better;
  logic             ask_better;

  assign sts.cnt_last = (cnt == AW'(ORDER_SLOTS - 1));
  assign rd_en        = cmd.rd_find || cmd.rd_best;
  assign diff         = price_q - lowest_price;

  always_comb begin
    case (func_q)
      lob_pkg::FUNC_ADD: begin
        if (hit) begin
          stat_now = lob_pkg::ST_DUP_ID;
        end else if (price_q < lowest_price || diff >= 32'(PRICE_LEVELS)) begin
          stat_now = lob_pkg::ST_RANGE;
        end else if (order_count >= CW'(ORDER_SLOTS) || !free_found) begin
          stat_now = lob_pkg::ST_FULL;
        end else begin
          stat_now = lob_pkg::ST_DONE;
        end
      end
      lob_pkg::FUNC_CANCEL: stat_now = hit ? lob_pkg::ST_DONE : lob_pkg::ST_UNKNOWN;
      lob_pkg::FUNC_EXEC: begin
        if (qty_q == 32'd0) begin
          stat_now = lob_pkg::ST_ZERO;
        end else if (!hit) begin
          stat_now = lob_pkg::ST_UNKNOWN;
        end else if (hit_word.qty < qty_q) begin
          stat_now = lob_pkg::ST_OVERFILL;
        end else begin
          stat_now = lob_pkg::ST_DONE;
        end
      end
      default: stat_now = lob_pkg::ST_UNKNOWN;
    endcase
  end

  // Store write selection: clearing sweep or the event's update.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = '0;
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.apply && stat_now == lob_pkg::ST_DONE) begin
      wr_en = 1'b1;
      case (func_q)
        lob_pkg::FUNC_ADD: begin
          wr_addr       = free_idx;
          wr_data.used  = 1'b1;
          wr_data.id    = id_q;
          wr_data.side  = side_q;
          wr_data.level = LW'(diff);
          wr_data.qty   = qty_q;
          wr_data.seq   = seq_ctr;
        end
        lob_pkg::FUNC_CANCEL: begin
          wr_addr      = hit_idx;
          wr_data      = hit_word;
          wr_data.used = 1'b0;
        end
        lob_pkg::FUNC_EXEC: begin
          wr_addr     = hit_idx;
          wr_data     = hit_word;
          wr_data.qty = hit_word.qty - qty_q;
          if (hit_word.qty == qty_q) begin
            wr_data.used = 1'b0;
          end
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[cnt];
    end
  end

  assign live       = rd_word.used && (rd_word.qty != 32'd0);
  assign bid_better = !bid_v || (rd_word.level > bid_lvl) ||
                      (rd_word.level == bid_lvl && rd_word.seq < bid_seq);
  assign ask_better = !ask_v || (rd_word.level < ask_lvl) ||
                      (rd_word.level == ask_lvl && rd_word.seq < ask_seq);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      order_count  <= '0;
      seq_ctr      <= '0;
      lowest_price <= '0;
      rd_find_v    <= 1'b0;
      rd_best_v    <= 1'b0;
    end else begin
      if (cfg_write) begin
        lowest_price <= cfg_data;
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (rd_en || cmd.clr_wr) begin
        cnt <= sts.cnt_last ? '0 : cnt + AW'(1);
      end
      rd_find_v <= cmd.rd_find;
      rd_best_v <= cmd.rd_best;
      if (cmd.apply && stat_now == lob_pkg::ST_DONE) begin
        case (func_q)
          lob_pkg::FUNC_ADD: begin
            order_count <= order_count + CW'(1);
            seq_ctr     <= seq_ctr + 64'd1;
          end
          lob_pkg::FUNC_CANCEL: order_count <= order_count - CW'(1);
          lob_pkg::FUNC_EXEC: begin
            if (hit_word.qty == qty_q) begin
              order_count <= order_count - CW'(1);
            end
          end
          default: order_count <= order_count;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= cnt;
    end
    if (cmd.load_in) begin
      func_q     <= lob_pkg::func_t'(func);
      id_q       <= evt_id;
      side_q     <= side;
      price_q    <= price;
      qty_q      <= quantity;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_find_v) begin
      if (rd_word.used && rd_word.id == id_q && !hit) begin
        hit      <= 1'b1;
        hit_idx  <= rd_idx;
        hit_word <= rd_word;
      end
      if (!rd_word.used && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
    if (cmd.apply) begin
      stat_q <= stat_now;
      bid_v  <= 1'b0;
      ask_v  <= 1'b0;
    end else if (rd_best_v && live) begin
      if (!rd_word.side && bid_better) begin
        bid_v   <= 1'b1;
        bid_lvl <= rd_word.level;
        bid_seq <= rd_word.seq;
        bid_id  <= rd_word.id;
      end
      if (rd_word.side && ask_better) begin
        ask_v   <= 1'b1;
        ask_lvl <= rd_word.level;
        ask_seq <= rd_word.seq;
        ask_id  <= rd_word.id;
      end
    end
    if (cmd.load_out) begin
      status       <= stat_q;
      bid_valid    <= bid_v;
      bid_price    <= bid_v ? lowest_price + 32'(bid_lvl) : 32'd0;
      bid_front_id <= bid_v ? bid_id : 64'd0;
      ask_valid    <= ask_v;
      ask_price    <= ask_v ? lowest_price + 32'(ask_lvl) : 32'd0;
      ask_front_id <= ask_v ? ask_id : 64'd0;
      live_orders  <= lob_pkg::LIVE_W'(order_count);
    end
  end

endmodule

FILE: rtl/limit_order_book.sv
// Top level of the limit order book: controller, datapath and checks.
//
// Usage. Events arrive on the input channel (in_valid / in_stall) carrying
// func, evt_id, side, price and quantity. Each accepted beat yields exactly
// one result beat on the output channel (out_valid / out_stall) with a status
// code, the best bid and best ask with the earliest live order id at each,
// and the number of stored orders. The user must write lowest_price through
// cfg_write and cfg_data only while no event is in flight; the block does not check.
//
// Timing. The order store is one single-port memory of ORDER_SLOTS entries.
// An event walks it twice, once to find the id and a free slot and once to
// find the best prices, one entry per cycle, and a new beat is taken once
// the previous result is loaded into the output register.
// Time priority comes from a sequence number stamped on every add; the
// earliest live order at the best level is the one with the smallest stamp.
//
// Reset. rst is synchronous and active high. After it the block sweeps the
// store clear, entry by entry, with in_stall high; lowest_price is zero.
// A result waits in the output register while out_stall is high; the block
// still accepts the next event and stalls only when that one is finished.
module limit_order_book #(
  parameter int ORDER_SLOTS  = lob_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_LEVELS = lob_pkg::PRICE_LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [31:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 func,
  input  logic [63:0]                evt_id,
  input  logic                       side,
  input  logic [31:0]                price,
  input  logic [31:0]                quantity,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 status,
  output logic                       bid_valid,
  output logic [31:0]                bid_price,
  output logic [63:0]                bid_front_id,
  output logic                       ask_valid,
  output logic [31:0]                ask_price,
  output logic [63:0]                ask_front_id,
  output logic [lob_pkg::LIVE_W-1:0] live_orders
);

  lob_pkg::lob_cmd_t cmd;
  lob_pkg::lob_sts_t sts;

  lob_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lob_dp #(
    .ORDER_SLOTS  (ORDER_SLOTS),
    .PRICE_LEVELS (PRICE_LEVELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .func         (func),
    .evt_id       (evt_id),
    .side         (side),
    .price        (price),
    .quantity     (quantity),
    .status       (status),
    .bid_valid    (bid_valid),
    .bid_price    (bid_price),
    .bid_front_id (bid_front_id),
    .ask_valid    (ask_valid),
    .ask_price    (ask_price),
    .ask_front_id (ask_front_id),
    .live_orders  (live_orders)
  );

  // An accepted event keeps the input side closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accepted beat");

  // A new result only appears while an event is being worked on.
  a_result_from_event: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without an event in flight");

  // An empty bid side reports zero price and zero id.
  a_empty_side_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bid_valid |-> bid_price == 32'd0 && bid_front_id == 64'd0)
    else $error("empty bid side carries a price or id");

endmodule
